/* rtl/tllik_pkg.sv */
// Shared types, constants and the CORDIC angle table for the leg IK block.
package tllik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int LINK_W           = 15;
  localparam int POS_W            = 16;
  localparam int ANGLE_W          = 16;
  localparam int CFG_IDX_W        = 4;
  localparam int STEP_W           = 5;
  localparam logic [LINK_W-1:0] LINK_RESET = 15'd3277;

  // Long division and square root both take one quotient or root bit per step
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;
  localparam logic [STEP_W-1:0] ROOT_LAST = 5'd30;

  // Q2.30 angle constants
  localparam logic signed [35:0] ANG_HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] ANG_THIRD_PI = 36'sd1124419809;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK = 4'd1;

  typedef enum logic [1:0] {
    ST_SOLVED  = 2'd0,
    ST_ZERO    = 2'd1,
    ST_UNREACH = 2'd2
  } solve_status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_SETUP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQR,
    OP_ROOT_STEP,
    OP_ROT_INIT,
    OP_ROT_STEP,
    OP_ACCUM,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [1:0]          sel;   // 0 knee ratio, 1 foot ratio, 2 hip ratio
    logic [STEP_W-1:0]   step;
    solve_status_t       code;
  } dp_cmd_t;

  typedef struct packed {
    logic same_height;
    logic zero_height;
    logic bad_ratio;
  } dp_stat_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [30:0] v;
    case (i)
      5'd0:    v = 31'd843314856;
      5'd1:    v = 31'd497837829;
      5'd2:    v = 31'd263043836;
      5'd3:    v = 31'd133525158;
      5'd4:    v = 31'd67021686;
      5'd5:    v = 31'd33543515;
      5'd6:    v = 31'd16775850;
      5'd7:    v = 31'd8388437;
      5'd8:    v = 31'd4194282;
      5'd9:    v = 31'd2097149;
      5'd10:   v = 31'd1048575;
      5'd11:   v = 31'd524287;
      5'd12:   v = 31'd262143;
      5'd13:   v = 31'd131071;
      5'd14:   v = 31'd65535;
      5'd15:   v = 31'd32767;
      5'd16:   v = 31'd16383;
      5'd17:   v = 31'd8191;
      5'd18:   v = 31'd4095;
      5'd19:   v = 31'd2047;
      5'd20:   v = 31'd1023;
      5'd21:   v = 31'd511;
      5'd22:   v = 31'd255;
      5'd23:   v = 31'd127;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Q2.30 to Q4.12 with rounding and saturation
  function automatic logic [ANGLE_W-1:0] to_q412(input logic signed [35:0] a);
    logic signed [35:0] v;
    logic [ANGLE_W-1:0] r;
    v = (a + 36'sd131072) >>> 18;
    if (v > 36'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -36'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tllik_ifs.sv */
// Channel interfaces: command input, result output and configuration write.
interface tllik_in_if import tllik_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  leg_height;
  logic signed [POS_W-1:0]  foot_offset;
  modport source (output valid, output leg_height, output foot_offset, input ready);
  modport sink   (input valid, input leg_height, input foot_offset, output ready);
endinterface

interface tllik_out_if import tllik_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  hip_angle;
  logic signed [ANGLE_W-1:0]  knee_angle;
  logic [1:0]                 solve_status;
  modport source (output valid, output hip_angle, output knee_angle, output solve_status,
                  input ready);
  modport sink   (input valid, input hip_angle, input knee_angle, input solve_status,
                  output ready);
endinterface

interface tllik_cfg_if import tllik_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [LINK_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tllik_dp.sv */
// Datapath: link registers, products, shared divider, square root and CORDIC.
module tllik_dp import tllik_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [POS_W-1:0]    leg_height,
  input  logic signed [POS_W-1:0]    foot_offset,
  input  logic                       cfg_wr,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [LINK_W-1:0]          cfg_data,
  output logic [ANGLE_W-1:0]         hip_angle,
  output logic [ANGLE_W-1:0]         knee_angle,
  output solve_status_t              solve_status
);

  logic [LINK_W-1:0]        l1, l2;
  logic [POS_W-1:0]         last_height;
  logic signed [POS_W-1:0]  h, x;
  logic [29:0]              l1sq, l2sq, l1l2;
  logic [30:0]              hsq;
  logic signed [31:0]       l1h;
  logic signed [33:0]       num, den;
  logic [33:0]              an, ad;
  logic [34:0]              rem;
  logic [33:0]              dmag;
  logic                     neg;
  logic [30:0]              q;
  logic signed [31:0]       t;
  logic [61:0]              rop, res, one, root_sum;
  logic signed [33:0]       cx, cy;
  logic signed [32:0]       cz;
  logic signed [35:0]       knee_acc, hip_acc;
  logic signed [31:0]       h_sq_full;

  assign an = num[33] ? 34'(-num) : 34'(num);
  assign ad = den[33] ? 34'(-den) : 34'(den);
  assign root_sum = res + one;
  assign h_sq_full = h * h;

  assign stat.same_height = (leg_height == last_height);
  assign stat.zero_height = (leg_height == '0);
  assign stat.bad_ratio   = (ad == '0) || (an > ad);

  // Configuration and the remembered height
  always_ff @(posedge clk) begin
    if (rst) begin
      l1          <= LINK_RESET;
      l2          <= LINK_RESET;
      last_height <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_UPPER_LINK: l1 <= cfg_data;
          REG_LOWER_LINK: l2 <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        last_height <= leg_height;
      end
    end
  end

  // Execute one datapath command per cycle
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        h <= leg_height;
        x <= foot_offset;
      end
      OP_MUL: begin
        l1sq     <= l1 * l1;
        l2sq     <= l2 * l2;
        l1l2     <= l1 * l2;
        hsq      <= h_sq_full[30:0];
        l1h      <= $signed({1'b0, l1}) * h;
        knee_acc <= ANG_HALF_PI + ANG_THIRD_PI;
        hip_acc  <= -ANG_HALF_PI;
      end
      OP_SETUP: begin
        case (cmd.sel)
          2'd0: begin
            num <= 34'(l1sq) + 34'(l2sq) - 34'(hsq);
            den <= {3'b0, l1l2, 1'b0};
          end
          2'd1: begin
            num <= 34'(x);
            den <= 34'(h);
          end
          default: begin
            num <= 34'(l1sq) + 34'(hsq) - 34'(l2sq);
            den <= 34'(l1h) <<< 1;
          end
        endcase
      end
      OP_DIV_INIT: begin
        rem  <= 35'(an);
        dmag <= ad;
        neg  <= num[33] ^ den[33];
        q    <= '0;
      end
      OP_DIV_STEP: begin
        // one quotient bit per step, remainder stays below twice the divisor
        if (rem >= 35'(dmag)) begin
          q   <= {q[29:0], 1'b1};
          rem <= (rem - 35'(dmag)) << 1;
        end else begin
          q   <= {q[29:0], 1'b0};
          rem <= rem << 1;
        end
      end
      OP_SQR: begin
        rop <= (62'd1 << 60) - (62'(q) * 62'(q));
        res <= '0;
        one <= 62'd1 << 60;
        t   <= neg ? -$signed(32'(q)) : $signed(32'(q));
      end
      OP_ROOT_STEP: begin
        if (rop >= root_sum) begin
          rop <= rop - root_sum;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
      end
      OP_ROT_INIT: begin
        cx <= $signed({3'b0, res[30:0]});
        cy <= 34'(t);
        cz <= '0;
      end
      OP_ROT_STEP: begin
        // vector toward the x axis, accumulate the angle
        if (!cy[33]) begin
          cx <= cx + (cy >>> cmd.step);
          cy <= cy - (cx >>> cmd.step);
          cz <= cz + $signed({2'b0, atan_q30(cmd.step)});
        end else begin
          cx <= cx - (cy >>> cmd.step);
          cy <= cy + (cx >>> cmd.step);
          cz <= cz - $signed({2'b0, atan_q30(cmd.step)});
        end
      end
      OP_ACCUM: begin
        if (cmd.sel == 2'd0) begin
          knee_acc <= knee_acc - 36'(cz);
        end else begin
          hip_acc <= hip_acc + 36'(cz);
        end
      end
      OP_RESULT: begin
        solve_status <= cmd.code;
        if (cmd.code == ST_SOLVED) begin
          hip_angle  <= to_q412(hip_acc);
          knee_angle <= to_q412(knee_acc);
        end else begin
          hip_angle  <= '0;
          knee_angle <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/tllik_ctrl.sv */
// Controller: sequences the solve and owns both handshakes.
module tllik_ctrl import tllik_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);

  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SETUP, S_CHECK, S_DIV, S_SQR, S_ROOT, S_RINIT, S_ROT,
    S_ACCUM, S_FINISH
  } state_t;

  state_t             state;
  logic [1:0]         sel;
  logic [STEP_W-1:0]  cnt;
  solve_status_t      code;
  logic               in_xfer, slot_free;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Command decode
  always_comb begin
    cmd.sel  = sel;
    cmd.step = cnt;
    cmd.code = code;
    case (state)
      S_IDLE:   cmd.op = in_xfer ? OP_LOAD : OP_NOP;
      S_PREP:   cmd.op = OP_MUL;
      S_SETUP:  cmd.op = OP_SETUP;
      S_CHECK:  cmd.op = OP_DIV_INIT;
      S_DIV:    cmd.op = OP_DIV_STEP;
      S_SQR:    cmd.op = OP_SQR;
      S_ROOT:   cmd.op = OP_ROOT_STEP;
      S_RINIT:  cmd.op = OP_ROT_INIT;
      S_ROT:    cmd.op = OP_ROT_STEP;
      S_ACCUM:  cmd.op = OP_ACCUM;
      S_FINISH: cmd.op = slot_free ? OP_RESULT : OP_NOP;
      default:  cmd.op = OP_NOP;
    endcase
  end

  // State, counters and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= '0;
      cnt       <= '0;
      code      <= ST_SOLVED;
      out_valid <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it after the transfer
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && !stat.same_height) begin
            if (stat.zero_height) begin
              code  <= ST_ZERO;
              state <= S_FINISH;
            end else begin
              sel   <= '0;
              state <= S_PREP;
            end
          end
        end
        S_PREP:  state <= S_SETUP;
        S_SETUP: state <= S_CHECK;
        S_CHECK: begin
          cnt <= '0;
          if (stat.bad_ratio) begin
            code  <= ST_UNREACH;
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROOT_LAST) begin
            state <= S_RINIT;
          end
        end
        S_RINIT: begin
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROT_LAST) begin
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (sel == 2'd2) begin
            code  <= ST_SOLVED;
            state <= S_FINISH;
          end else begin
            sel   <= sel + 1'b1;
            state <= S_SETUP;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/two_link_leg_inverse_kinematics_top.sv */
// Top level of the two-link leg inverse kinematics solver.
// Each command transfer carries a leg height and a forward foot offset (Q1.15 m). A command
// whose height equals the last height acted on gives no result; any other gives one result
// with hip and knee angles in Q4.12 radians and a status (solved, zero height, unreachable).
// A full solve runs three ratios in turn through one shared radix-2 divider, a bit-serial
// square root and a CORDIC arcsine; a zero height or an unreachable ratio finishes early.
// A new command is taken once the previous one is done, while its result may still wait in
// the output register. Link lengths are written on the configuration channel (index 0
// upper link, 1 lower link); the user must write them only while the block is idle, as
// the block itself does not enforce it.
module two_link_leg_inverse_kinematics_top import tllik_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tllik_in_if.sink      req,
  tllik_out_if.source   rsp,
  tllik_cfg_if.sink     cfg
);

  dp_cmd_t        cmd;
  dp_stat_t       stat;
  solve_status_t  status;
  logic [ANGLE_W-1:0] hip, knee;

  // Configuration is always taken
  assign cfg.ready = 1'b1;

  tllik_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tllik_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .leg_height   (req.leg_height),
    .foot_offset  (req.foot_offset),
    .cfg_wr       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .hip_angle    (hip),
    .knee_angle   (knee),
    .solve_status (status)
  );

  assign rsp.hip_angle    = $signed(hip);
  assign rsp.knee_angle   = $signed(knee);
  assign rsp.solve_status = status;

endmodule

/* verif/tb.sv */
// Testbench for the two-link leg inverse kinematics solver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tllik_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int SETTLE = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd3;
  localparam longint Q30_ONE = 64'sd1073741824;

  typedef struct packed {
    logic signed [POS_W-1:0] height;
    logic signed [POS_W-1:0] offset;
  } leg_cmd_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] hip;
    logic signed [ANGLE_W-1:0] knee;
    solve_status_t             status;
  } joint_target_t;

  logic clk;
  logic rst;
  tllik_in_if  req ();
  tllik_out_if rsp ();
  tllik_cfg_if cfg ();

  two_link_leg_inverse_kinematics_top uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // Solver model state
  logic [LINK_W-1:0] upper_len;
  logic [LINK_W-1:0] lower_len;
  logic [POS_W-1:0]  held_height;

  leg_cmd_t      pending_cmds[$];
  joint_target_t expected_targets[$];
  int            errors;
  bit            steady;

  // Floor square root of a 64-bit value
  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned op, res, one;
    op = n;
    res = 0;
    one = 64'd1 << 62;
    while (one > op) one = one >> 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // Q1.30 quotient truncated toward zero; zero return means out of range
  function automatic bit q30_ratio(input longint num, input longint den, output longint q);
    longint unsigned an, ad, m;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = 0;
    if (ad == 0 || an > ad) return 0;
    m = (an << 30) / ad;
    q = ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
    return 1;
  endfunction

  // CORDIC vectoring arcsine, Q1.30 in, Q2.30 out
  function automatic longint cordic_asin(input longint t);
    longint x, y, z, nx;
    x = longint'(root64(Q30_ONE * Q30_ONE - t * t));
    y = t;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(atan_q30(i[STEP_W-1:0]));
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(atan_q30(i[STEP_W-1:0]));
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [ANGLE_W-1:0] angle_q412(input longint a);
    longint v;
    v = (a + 64'sd131072) >>> 18;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[ANGLE_W-1:0];
  endfunction

  // Predict the joint targets for one accepted command
  task automatic predict_joints(input leg_cmd_t c);
    longint h, x, l1, l2, qk, qx, qa;
    joint_target_t r;
    h = c.height;
    x = c.offset;
    l1 = upper_len;
    l2 = lower_len;
    if (c.height == held_height) return;
    held_height = c.height;
    r = '0;
    if (h == 0) begin
      r.status = ST_ZERO;
    end else if (!q30_ratio(l1 * l1 + l2 * l2 - h * h, 2 * l1 * l2, qk) ||
                 !q30_ratio(x, h, qx) ||
                 !q30_ratio(l1 * l1 + h * h - l2 * l2, 2 * l1 * h, qa)) begin
      r.status = ST_UNREACH;
    end else begin
      r.knee = angle_q412(ANG_HALF_PI + ANG_THIRD_PI - cordic_asin(qk));
      r.hip = angle_q412(cordic_asin(qx) - ANG_HALF_PI + cordic_asin(qa));
      r.status = ST_SOLVED;
    end
    expected_targets = {expected_targets, r};
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Command driver: predict on each transfer, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) predict_joints({req.leg_height, req.foot_offset});
      if ((!req.valid || req.ready) && pending_cmds.size() > 0 &&
          (steady || $urandom_range(99) >= 29)) begin
        leg_cmd_t c;
        c = pending_cmds.pop_front();
        req.valid <= 1'b1;
        req.leg_height <= c.height;
        req.foot_offset <= c.offset;
      end else if (req.valid && req.ready) begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result monitor: stall at random and compare each transfer
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= steady || $urandom_range(99) >= 29;
      if (rsp.valid && rsp.ready) begin
        if (expected_targets.size() == 0) begin
          $display("%0t: unexpected result hip=%0d knee=%0d status=%0d", $realtime,
                   rsp.hip_angle, rsp.knee_angle, rsp.solve_status);
          errors++;
        end else begin
          joint_target_t e;
          e = expected_targets.pop_front();
          if (rsp.hip_angle !== e.hip) begin
            $display("%0t: hip expected %0d actual %0d", $realtime, e.hip, rsp.hip_angle);
            errors++;
          end
          if (rsp.knee_angle !== e.knee) begin
            $display("%0t: knee expected %0d actual %0d", $realtime, e.knee, rsp.knee_angle);
            errors++;
          end
          if (rsp.solve_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                     rsp.solve_status);
            errors++;
          end
        end
      end
    end
  end

  // Write one link register, mirror it in the model
  task automatic write_link(input logic [CFG_IDX_W-1:0] idx, input logic [LINK_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_UPPER_LINK) upper_len = val;
    else if (idx == REG_LOWER_LINK) lower_len = val;
  endtask

  task automatic queue_cmd(input int h, input int x);
    leg_cmd_t c;
    c.height = h[POS_W-1:0];
    c.offset = x[POS_W-1:0];
    pending_cmds = {pending_cmds, c};
  endtask

  // Mostly reachable commands with random content, some noise and repeats
  task automatic queue_random(input int n);
    int reach, h, x, last;
    last = 0;
    reach = upper_len + lower_len;
    if (reach > 32767) reach = 32767;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        h = last;
      end else if ($urandom_range(99) < 75) begin
        h = $urandom_range(reach, 1);
        if ($urandom_range(1)) h = -h;
      end else begin
        h = $signed(16'($urandom));
      end
      if ($urandom_range(99) < 85 && h != 0) begin
        x = $urandom_range((h < 0) ? -h : h, 0);
        if ($urandom_range(1)) x = -x;
      end else begin
        x = $signed(16'($urandom));
      end
      queue_cmd(h, x);
      last = h;
    end
  endtask

  // Wait until every command is taken and every result has come back
  task automatic drain;
    do @(posedge clk);
    while (pending_cmds.size() > 0 || req.valid || expected_targets.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    steady = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.leg_height = '0;
    req.foot_offset = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    upper_len = LINK_RESET;
    lower_len = LINK_RESET;
    held_height = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset height, repeats, zero, extremes, unreachable, edge ratios
    queue_cmd(0, 100);
    queue_cmd(4000, 0);
    queue_cmd(4000, 1000);
    queue_cmd(0, 0);
    queue_cmd(-4000, 0);
    queue_cmd(6554, 6554);
    queue_cmd(6554, -6554);
    queue_cmd(32767, 32767);
    queue_cmd(-32768, -32768);
    queue_cmd(5000, 32767);
    queue_cmd(-5000, -32768);
    queue_cmd(1, 0);
    queue_cmd(-1, 1);
    queue_cmd(3277, -3277);
    queue_cmd(5, 3);
    drain();

    // Random phases across link settings, extremes included
    queue_random(100);
    drain();
    write_link(REG_UPPER_LINK, 15'd32767);
    write_link(REG_LOWER_LINK, 15'd32767);
    steady = 1;
    queue_random(80);
    drain();
    steady = 0;
    write_link(REG_UPPER_LINK, 15'd1);
    write_link(REG_LOWER_LINK, 15'd1);
    queue_cmd(1, 1);
    queue_cmd(2, -2);
    queue_cmd(3, 0);
    queue_random(30);
    drain();
    write_link(REG_UPPER_LINK, 15'd4000);
    write_link(REG_LOWER_LINK, 15'd2500);
    write_link(REG_UNUSED, 15'd123);
    queue_random(80);
    drain();
    write_link(REG_UPPER_LINK, 15'($urandom_range(32767, 1)));
    write_link(REG_LOWER_LINK, 15'($urandom_range(32767, 1)));
    queue_random(80);
    drain();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

endmodule
